/* rtl/core/ple_pkg.sv */
// Shared types and codes for the positional list engine.
// Holds channel payload structs, request and status codes, and the
// command/status structs between controller and datapath. No dependencies.
package ple_pkg;

  localparam int DEF_CAPACITY    = 64;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int OP_W   = 3;
  localparam int POS_W  = 6;
  localparam int ITEM_W = 32;
  localparam int STAT_W = 3;
  localparam int LEN_W  = 7;

  localparam logic [OP_W-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] REQ_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] REQ_INS_AT    = 3'd2;
  localparam logic [OP_W-1:0] REQ_DEL_AT    = 3'd3;
  localparam logic [OP_W-1:0] REQ_UPD_AT    = 3'd4;
  localparam logic [OP_W-1:0] REQ_SEARCH    = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]          req_type;
    logic [POS_W-1:0]         position;
    logic signed [ITEM_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  found_position;
    logic [LEN_W-1:0]  list_length;
  } rsp_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic              wr_item;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              load_req;
    logic              load_rsp;
    logic              found_en;
    logic [STAT_W-1:0] rsp_status;
  } ple_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            pos_gt;
    logic            pos_ge;
    logic            match;
  } ple_sts_t;

endpackage

/* rtl/core/ple_datapath.sv */
// Datapath of the positional list engine: request register, entry memory,
// length count, compare logic and result register.
// Depends on ple_pkg; driven by ple_ctrl through ple_cmd_t.
module ple_datapath
  import ple_pkg::*;
#(
  parameter int CAPACITY    = DEF_CAPACITY,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  req_t                         req,
  input  ple_cmd_t                     cmd,
  input  logic [$clog2(CAPACITY)-1:0]  rd_addr,
  input  logic [$clog2(CAPACITY)-1:0]  wr_addr,
  input  logic [$clog2(CAPACITY)-1:0]  found_idx,
  output ple_sts_t                     sts,
  output logic [$clog2(CAPACITY+1)-1:0] count,
  output logic [$clog2(CAPACITY+1)-1:0] pos_cut,
  output rsp_t                         rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int FW = (AW > POS_W) ? AW : POS_W;
  localparam int LW = (CW > LEN_W) ? CW : LEN_W;

  req_t                   req_q;
  logic [VALUE_WIDTH-1:0] val;
  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] rdata;
  logic [XW-1:0]          pos_x;
  logic [XW-1:0]          cnt_x;
  logic [FW-1:0]          fnd_x;
  logic [LW-1:0]          len_x;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
    end
  end

  // Sign-extend or truncate the request value to the stored width
  generate
    if (VALUE_WIDTH > ITEM_W) begin : g_ext
      assign val = {{(VALUE_WIDTH-ITEM_W){req_q.item_value[ITEM_W-1]}}, req_q.item_value};
    end else begin : g_cut
      assign val = req_q.item_value[VALUE_WIDTH-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= cmd.wr_item ? val : rdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

  assign pos_x   = XW'(req_q.position);
  assign cnt_x   = XW'(count);
  assign pos_cut = pos_x[CW-1:0];

  assign sts.op     = req_q.req_type;
  assign sts.empty  = (count == '0);
  assign sts.full   = (count == CW'(CAPACITY));
  assign sts.pos_gt = (pos_x > cnt_x);
  assign sts.pos_ge = (pos_x >= cnt_x);
  assign sts.match  = (rdata == val);

  assign fnd_x = FW'(found_idx);
  assign len_x = LW'(count);

  always_ff @(posedge clk) begin
    if (cmd.load_rsp) begin
      rsp.status         <= cmd.rsp_status;
      rsp.found_position <= cmd.found_en ? fnd_x[POS_W-1:0] : '0;
      rsp.list_length    <= len_x[LEN_W-1:0];
    end
  end

endmodule

/* rtl/core/ple_ctrl.sv */
// Controller of the positional list engine: request sequencing, shift and
// scan pointers, and the result handshake.
// Depends on ple_pkg; commands ple_datapath through ple_cmd_t.
module ple_ctrl
  import ple_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  input  ple_sts_t                      sts,
  input  logic [$clog2(CAPACITY+1)-1:0] count,
  input  logic [$clog2(CAPACITY+1)-1:0] pos_cut,
  output ple_cmd_t                      cmd,
  output logic [$clog2(CAPACITY)-1:0]   rd_addr,
  output logic [$clog2(CAPACITY)-1:0]   wr_addr,
  output logic [$clog2(CAPACITY)-1:0]   found_idx
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_UP     = 3'd2;
  localparam logic [2:0] S_PLACE  = 3'd3;
  localparam logic [2:0] S_DOWN   = 3'd4;
  localparam logic [2:0] S_SEARCH = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]        state, state_next;
  logic [CW-1:0]     ptr, ptr_next;
  logic [CW-1:0]     tgt, tgt_next;
  logic [AW-1:0]     tag, tag_next;
  logic              pend, pend_next;
  logic [STAT_W-1:0] st, st_next;
  logic              fnd, fnd_next;
  logic [CW-1:0]     ptr_inc, ptr_dec;

  assign ptr_inc   = ptr + CW'(1);
  assign ptr_dec   = ptr - CW'(1);
  assign found_idx = tag;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    ptr_next   = ptr;
    tgt_next   = tgt;
    tag_next   = tag;
    pend_next  = pend;
    st_next    = st;
    fnd_next   = fnd;
    rd_addr    = ptr[AW-1:0];
    wr_addr    = tag;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        st_next    = ST_OK;
        fnd_next   = 1'b0;
        pend_next  = 1'b0;
        state_next = S_FINISH;
        case (sts.op)
          REQ_INS_FRONT: begin
            if (sts.full) begin
              st_next = ST_FULL;
            end else begin
              tgt_next   = '0;
              ptr_next   = count;
              state_next = S_UP;
            end
          end
          REQ_INS_BACK: begin
            if (sts.full) begin
              st_next = ST_FULL;
            end else begin
              tgt_next   = count;
              ptr_next   = count;
              state_next = S_UP;
            end
          end
          REQ_INS_AT: begin
            if (sts.empty) begin
              st_next = ST_EMPTY;
            end else if (sts.pos_gt) begin
              st_next = ST_RANGE;
            end else if (sts.full) begin
              st_next = ST_FULL;
            end else begin
              tgt_next   = pos_cut;
              ptr_next   = count;
              state_next = S_UP;
            end
          end
          REQ_DEL_AT: begin
            if (sts.empty) begin
              st_next = ST_EMPTY;
            end else if (sts.pos_ge) begin
              st_next = ST_RANGE;
            end else begin
              ptr_next   = pos_cut + CW'(1);
              state_next = S_DOWN;
            end
          end
          REQ_UPD_AT: begin
            if (sts.empty) begin
              st_next = ST_EMPTY;
            end else if (sts.pos_ge) begin
              st_next = ST_RANGE;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_item = 1'b1;
              wr_addr     = pos_cut[AW-1:0];
            end
          end
          REQ_SEARCH: begin
            st_next    = ST_NOTFOUND;
            ptr_next   = '0;
            state_next = S_SEARCH;
          end
          default: ;
        endcase
      end
      S_UP: begin
        // read entry ptr-1 while the previous read lands one place higher
        cmd.rd_en = (ptr > tgt);
        cmd.wr_en = pend;
        rd_addr   = ptr_dec[AW-1:0];
        pend_next = cmd.rd_en;
        if (cmd.rd_en) begin
          tag_next = ptr[AW-1:0];
          ptr_next = ptr_dec;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_item = 1'b1;
        cmd.cnt_inc = 1'b1;
        wr_addr     = tgt[AW-1:0];
        state_next  = S_FINISH;
      end
      S_DOWN: begin
        // read entry ptr while the previous read lands one place lower
        cmd.rd_en = (ptr < count);
        cmd.wr_en = pend;
        pend_next = cmd.rd_en;
        if (cmd.rd_en) begin
          tag_next = ptr_dec[AW-1:0];
          ptr_next = ptr_inc;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_FINISH;
        end
      end
      S_SEARCH: begin
        if (pend && sts.match) begin
          st_next    = ST_OK;
          fnd_next   = 1'b1;
          pend_next  = 1'b0;
          state_next = S_FINISH;
        end else begin
          cmd.rd_en = (ptr < count);
          pend_next = cmd.rd_en;
          if (cmd.rd_en) begin
            tag_next = ptr[AW-1:0];
            ptr_next = ptr_inc;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.load_rsp   = 1'b1;
          cmd.rsp_status = st;
          cmd.found_en   = fnd;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pend      <= pend_next;
      rsp_valid <= cmd.load_rsp | (rsp_valid & rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    tgt <= tgt_next;
    tag <= tag_next;
    st  <= st_next;
    fnd <= fnd_next;
  end

endmodule

/* rtl/core/positional_list_engine_top.sv */
// Top level of the positional list engine.
// Depends on ple_pkg; instantiates ple_ctrl and ple_datapath.
//   req channel (req_valid, req_stall, req) carries one request per transfer:
//   insert front, insert back, insert at, delete at, update at or search.
//   rsp channel (rsp_valid, rsp_stall, rsp) returns exactly one result per
//   request: status, found position and list length after the request.
//   Requests are served one at a time. req_stall is low only while the
//   engine is idle; a request is taken even while the previous result
//   still sits in the output register.
//   Update, rejected requests and unknown request types go from the decision
//   straight to the result; insert at position t first shifts the entries
//   from t up by one, delete at p shifts the entries above p down by one, and
//   a search reads from entry 0 until a hit or the end of the list. The next
//   request can be taken in the cycle after the result is loaded. One entry
//   moves or is read per cycle, so the longest requests are an insert at the
//   front of a nearly full list and a search miss on a full one.
//   Reset clears the length and drops any pending result; entries are only
//   read after being written. While rsp_stall is high the result is held and
//   the engine waits with its next result until the output register frees.
module positional_list_engine_top
  import ple_pkg::*;
#(
  parameter int CAPACITY    = DEF_CAPACITY,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  ple_cmd_t      cmd;
  ple_sts_t      sts;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] found_idx;
  logic [CW-1:0] count;
  logic [CW-1:0] pos_cut;

  // Sequence each request: decide, shift or scan, then hand over the result
  ple_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .count     (count),
    .pos_cut   (pos_cut),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .found_idx (found_idx)
  );

  // Hold the entries, the length and the result register
  ple_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .found_idx (found_idx),
    .sts       (sts),
    .count     (count),
    .pos_cut   (pos_cut),
    .rsp       (rsp)
  );

  // The length never passes the store size
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("list length above capacity");

  // A taken request closes the input until it has been served
  a_busy_after_transfer : assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while busy");

  // A full status is only reported with a full list
  a_full_len : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_FULL) |-> (rsp.list_length == LEN_W'(CAPACITY)))
    else $error("full status with list not full");

  // Found position is zero unless the result is a successful search
  a_found_zero : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |-> (rsp.found_position == '0))
    else $error("found position set on failed request");

endmodule
